>>> rtl/core/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared constants, storage row types and controller/datapath interface
// structs of the signature/stride RRIP replacement unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int SIG_ENTRIES  = 8;
  localparam int STRIDE_DEPTH = 8;
  localparam int ADDR_BITS    = 48;

  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int WAY_BITS    = 4;
  localparam int SIG_BITS    = 16;
  localparam int CNT_BITS    = 4;
  localparam int RRIP_BITS   = 2;
  localparam int THR_BITS    = 4;
  localparam int INS_BITS    = 5;
  localparam int STRIDE_BITS = ADDR_BITS + 1;
  localparam int SCNT_BITS   = $clog2(STRIDE_DEPTH + 1);
  localparam int SLOT_BITS   = (SIG_ENTRIES > 1) ? $clog2(SIG_ENTRIES) : 1;

  localparam logic [RRIP_BITS-1:0] RR_MAX  = 2'd3;
  localparam logic [RRIP_BITS-1:0] RR_MID  = 2'd2;
  localparam logic [RRIP_BITS-1:0] RR_NEAR = 2'd0;
  localparam logic [CNT_BITS-1:0]  COUNT_MAX = 4'd15;

  localparam logic [THR_BITS-1:0] REUSE_THR_RESET  = 4'd2;
  localparam logic [THR_BITS-1:0] STRIDE_THR_RESET = 4'd6;

  // register map, index = paddr[2]
  localparam logic REG_REUSE_THR  = 1'b0;
  localparam logic REG_STRIDE_THR = 1'b1;

  typedef struct packed {
    logic [RRIP_BITS-1:0] rrip;
    logic [SIG_BITS-1:0]  sig;
    logic [ADDR_BITS-1:0] addr;
  } way_entry_t;

  typedef way_entry_t [NUM_WAYS-1:0] way_row_t;

  typedef struct packed {
    logic                valid;
    logic [SIG_BITS-1:0] sig;
    logic [CNT_BITS-1:0] cnt;
  } rt_entry_t;

  typedef rt_entry_t [SIG_ENTRIES-1:0] rt_row_t;

  typedef logic [STRIDE_DEPTH-1:0][STRIDE_BITS-1:0] hist_row_t;

  typedef struct packed {
    logic [SCNT_BITS-1:0] scnt;
    logic [ADDR_BITS-1:0] prev;
    logic [INS_BITS-1:0]  ins;
  } set_meta_t;

  typedef struct packed {
    logic                load;
    logic                clear;
    logic [SET_BITS-1:0] clear_idx;
    logic                strm;
    logic                scan;
    logic [WAY_BITS-1:0] way_idx;
    logic                fin;
    logic                upd1;
    logic                upd2;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_stop;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ssr_ram.sv
// ----------------------------------------------------------------------------
// ssr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/ssr_ctrl.sv
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: clearing pass, row fetch, way scan for queries and the two
// training steps for updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              kind,
  input  wire ssr_pkg::dp_stat_t stat,
  output ssr_pkg::dp_cmd_t       cmd,
  output logic                   busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_STRM  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_UPD1  = 3'd6;
  localparam logic [2:0] S_UPD2  = 3'd7;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [ssr_pkg::SET_BITS-1:0] clr_idx;
  logic [ssr_pkg::WAY_BITS-1:0] wcnt;
  logic                         is_upd;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == ssr_pkg::SET_BITS'(ssr_pkg::NUM_SETS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_LOAD;
      end
      S_LOAD: state_next = is_upd ? S_UPD1 : S_STRM;
      S_STRM: state_next = S_SCAN;
      S_SCAN: begin
        if (stat.scan_stop || wcnt == ssr_pkg::WAY_BITS'(ssr_pkg::NUM_WAYS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN:  state_next = S_IDLE;
      S_UPD1: state_next = S_UPD2;
      S_UPD2: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      wcnt    <= '0;
      is_upd  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == S_STRM) wcnt <= '0;
      if (state == S_SCAN) wcnt <= wcnt + 1'b1;
      if (state == S_IDLE && start) is_upd <= kind;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && start;
    cmd.clear     = (state == S_CLEAR);
    cmd.clear_idx = clr_idx;
    cmd.strm      = (state == S_STRM);
    cmd.scan      = (state == S_SCAN);
    cmd.way_idx   = wcnt;
    cmd.fin       = (state == S_FIN);
    cmd.upd1      = (state == S_UPD1);
    cmd.upd2      = (state == S_UPD2);
  end

`ifndef NO_ASSERTIONS
  a_upd_two_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD1) |=> (state == S_UPD2))
    else $error("update step skipped");
  a_scan_from_strm: assert property (@(posedge clk) disable iff (rst)
    (state == S_STRM) |=> (state == S_SCAN && wcnt == '0))
    else $error("scan did not start at way zero");
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == S_CLEAR && clr_idx == '0))
    else $error("reset did not start clearing pass");
`endif

endmodule

`default_nettype wire

>>> rtl/core/ssr_dp.sv
// ----------------------------------------------------------------------------
// ssr_dp
// Datapath: per-set row memories, stride detector, reuse table training,
// way scan registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ssr_pkg::dp_cmd_t                  cmd,
  input  wire logic [ssr_pkg::SET_BITS-1:0]      set_in,
  input  wire logic [ssr_pkg::WAY_BITS-1:0]      way_in,
  input  wire logic [ssr_pkg::ADDR_BITS-1:0]     addr_in,
  input  wire logic [ssr_pkg::SIG_BITS-1:0]      pc_in,
  input  wire logic                              hit_in,
  input  wire logic [ssr_pkg::THR_BITS-1:0]      reuse_thr,
  input  wire logic [ssr_pkg::THR_BITS-1:0]      stride_thr,
  output ssr_pkg::dp_stat_t                      stat,
  output logic                                   done,
  output logic [ssr_pkg::WAY_BITS-1:0]           victim_way,
  output logic                                   streaming_seen
);

  // ---------------- helpers ----------------
  function automatic logic strm_f(ssr_pkg::hist_row_t h,
                                  logic [ssr_pkg::SCNT_BITS-1:0] c,
                                  logic [ssr_pkg::STRIDE_BITS-1:0] s,
                                  logic [ssr_pkg::THR_BITS-1:0] thr);
    logic [ssr_pkg::SCNT_BITS-1:0] m;
    m = '0;
    for (int k = 0; k < ssr_pkg::STRIDE_DEPTH; k++) begin
      if ((ssr_pkg::SCNT_BITS'(k) < c) && (h[k] == s)) m = m + 1'b1;
    end
    if (s == '0 || c < thr) m = '0;
    return (m >= thr);
  endfunction

  function automatic logic [ssr_pkg::CNT_BITS-1:0] reuse_f(ssr_pkg::rt_row_t row,
                                                          logic [ssr_pkg::SIG_BITS-1:0] sig);
    logic [ssr_pkg::CNT_BITS-1:0] r;
    r = '0;
    for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
      if (row[e].valid && row[e].sig == sig) r = row[e].cnt;
    end
    return r;
  endfunction

  // ---------------- input registers ----------------
  logic [ssr_pkg::SET_BITS-1:0]  set_q;
  logic [ssr_pkg::WAY_BITS-1:0]  way_q;
  logic [ssr_pkg::ADDR_BITS-1:0] addr_q;
  logic [ssr_pkg::SIG_BITS-1:0]  pc_q;
  logic                          hit_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      set_q  <= set_in;
      way_q  <= way_in;
      addr_q <= addr_in;
      pc_q   <= pc_in;
      hit_q  <= hit_in;
    end
  end

  // ---------------- memories ----------------
  ssr_pkg::way_row_t  way_rd, way_wr;
  ssr_pkg::rt_row_t   rt_rd, rt_wr;
  ssr_pkg::hist_row_t hist_rd;
  ssr_pkg::set_meta_t meta_rd, meta_wr;
  logic way_we, rt_we, meta_we, hist_we;
  logic [ssr_pkg::SET_BITS-1:0] waddr;

  logic [$bits(ssr_pkg::way_row_t)-1:0]  way_rdata;
  logic [$bits(ssr_pkg::rt_row_t)-1:0]   rt_rdata;
  logic [$bits(ssr_pkg::hist_row_t)-1:0] hist_rdata;
  logic [$bits(ssr_pkg::set_meta_t)-1:0] meta_rdata;

  assign way_rd  = ssr_pkg::way_row_t'(way_rdata);
  assign rt_rd   = ssr_pkg::rt_row_t'(rt_rdata);
  assign hist_rd = ssr_pkg::hist_row_t'(hist_rdata);
  assign meta_rd = ssr_pkg::set_meta_t'(meta_rdata);

  assign waddr = cmd.clear ? cmd.clear_idx : set_q;

  ssr_pkg::hist_row_t hist_n;

  ssr_ram #(.WIDTH($bits(ssr_pkg::way_row_t)), .DEPTH(ssr_pkg::NUM_SETS)) u_way_ram (
    .clk(clk), .we(way_we), .waddr(waddr), .wdata(way_wr), .raddr(set_q), .rdata(way_rdata)
  );
  ssr_ram #(.WIDTH($bits(ssr_pkg::rt_row_t)), .DEPTH(ssr_pkg::NUM_SETS)) u_rt_ram (
    .clk(clk), .we(rt_we), .waddr(waddr), .wdata(rt_wr), .raddr(set_q), .rdata(rt_rdata)
  );
  ssr_ram #(.WIDTH($bits(ssr_pkg::hist_row_t)), .DEPTH(ssr_pkg::NUM_SETS)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(waddr), .wdata(hist_n), .raddr(set_q), .rdata(hist_rdata)
  );
  ssr_ram #(.WIDTH($bits(ssr_pkg::set_meta_t)), .DEPTH(ssr_pkg::NUM_SETS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(waddr), .wdata(meta_wr), .raddr(set_q), .rdata(meta_rdata)
  );

  // ---------------- stride ----------------
  logic [ssr_pkg::STRIDE_BITS-1:0] stride;
  logic [ssr_pkg::STRIDE_BITS-1:0] stride_q;
  logic [ssr_pkg::SIG_BITS-1:0]    sig;

  // 49-bit difference holds every 48-bit address delta exactly
  assign stride = (meta_rd.prev == '0) ? '0 : ({1'b0, addr_q} - {1'b0, meta_rd.prev});
  assign sig    = pc_q ^ addr_q[ssr_pkg::SIG_BITS+5:6];

  // ---------------- update step 1: history push and table training ----------
  ssr_pkg::hist_row_t           hist_c;
  logic [ssr_pkg::SCNT_BITS-1:0] scnt_c;
  ssr_pkg::rt_row_t             rt_c;
  logic [ssr_pkg::CNT_BITS-1:0] rnew_c;

  always_comb begin
    hist_c = hist_rd;
    scnt_c = meta_rd.scnt;
    if (stride != '0) begin
      if (meta_rd.scnt >= ssr_pkg::SCNT_BITS'(ssr_pkg::STRIDE_DEPTH)) begin
        for (int k = 0; k < ssr_pkg::STRIDE_DEPTH - 1; k++) hist_c[k] = hist_rd[k+1];
        hist_c[ssr_pkg::STRIDE_DEPTH-1] = stride;
      end else begin
        for (int k = 0; k < ssr_pkg::STRIDE_DEPTH; k++) begin
          if (ssr_pkg::SCNT_BITS'(k) == meta_rd.scnt) hist_c[k] = stride;
        end
        scnt_c = meta_rd.scnt + 1'b1;
      end
    end
  end

  always_comb begin
    logic                          found, found2, full, best_v, ins_done;
    logic [ssr_pkg::SLOT_BITS-1:0] fidx, best_i;
    logic [ssr_pkg::CNT_BITS-1:0]  best_c;
    found    = 1'b0;
    found2   = 1'b0;
    full     = 1'b1;
    best_v   = 1'b0;
    ins_done = 1'b0;
    fidx     = '0;
    best_i   = '0;
    best_c   = '0;
    rt_c     = rt_rd;
    rnew_c   = 4'd1;
    for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
      if (!found && rt_rd[e].valid && rt_rd[e].sig == sig) begin
        found = 1'b1;
        fidx  = ssr_pkg::SLOT_BITS'(e);
      end
      if (!rt_rd[e].valid) full = 1'b0;
      if (rt_rd[e].valid && (!best_v || rt_rd[e].cnt < best_c)) begin
        best_v = 1'b1;
        best_i = ssr_pkg::SLOT_BITS'(e);
        best_c = rt_rd[e].cnt;
      end
    end
    if (hit_q && found) begin
      for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
        if (ssr_pkg::SLOT_BITS'(e) == fidx && rt_rd[e].cnt < ssr_pkg::COUNT_MAX) begin
          rt_c[e].cnt = rt_rd[e].cnt + 1'b1;
        end
      end
      for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
        if (ssr_pkg::SLOT_BITS'(e) == fidx) rnew_c = rt_c[e].cnt;
      end
    end else begin
      // full table: drop the lowest-count entry, lowest slot on ties
      if (full) begin
        for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
          if (ssr_pkg::SLOT_BITS'(e) == best_i) rt_c[e].valid = 1'b0;
        end
      end
      for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
        if (!found2 && rt_c[e].valid && rt_c[e].sig == sig) begin
          found2      = 1'b1;
          rt_c[e].cnt = 4'd1;
        end
      end
      if (!found2) begin
        for (int e = 0; e < ssr_pkg::SIG_ENTRIES; e++) begin
          if (!ins_done && !rt_c[e].valid) begin
            ins_done      = 1'b1;
            rt_c[e].valid = 1'b1;
            rt_c[e].sig   = sig;
            rt_c[e].cnt   = 4'd1;
          end
        end
      end
    end
  end

  logic [ssr_pkg::SCNT_BITS-1:0] scnt_n;
  ssr_pkg::rt_row_t              rt_n;
  logic [ssr_pkg::CNT_BITS-1:0]  rnew_q;

  always_ff @(posedge clk) begin
    if (cmd.upd1) begin
      hist_n <= hist_c;
      scnt_n <= scnt_c;
      rt_n   <= rt_c;
      rnew_q <= rnew_c;
    end
    if (cmd.upd1 || cmd.strm) stride_q <= stride;
  end

  // ---------------- update step 2: insertion value ----------------
  logic                          st2;
  logic [ssr_pkg::INS_BITS-1:0]  ins_n;
  logic [ssr_pkg::RRIP_BITS-1:0] ins_rrip;
  logic                          way_ok;
  ssr_pkg::way_row_t             way_upd;

  assign st2    = strm_f(hist_n, scnt_n, stride_q, stride_thr);
  assign ins_n  = (st2 && !hit_q) ? meta_rd.ins + 1'b1 : meta_rd.ins;
  assign way_ok = ({1'b0, way_q} < (ssr_pkg::WAY_BITS + 1)'(ssr_pkg::NUM_WAYS));

  always_comb begin
    if (st2) begin
      ins_rrip = (!hit_q && ins_n != '0) ? ssr_pkg::RR_MAX : ssr_pkg::RR_NEAR;
    end else begin
      ins_rrip = (rnew_q >= reuse_thr) ? ssr_pkg::RR_NEAR : ssr_pkg::RR_MID;
    end
    way_upd = way_rd;
    for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
      if (ssr_pkg::WAY_BITS'(w) == way_q) begin
        way_upd[w].rrip = ins_rrip;
        way_upd[w].sig  = sig;
        way_upd[w].addr = addr_q;
      end
    end
  end

  // ---------------- query: streaming and way scan ----------------
  logic                          st_q;
  logic                          vfound;
  logic [ssr_pkg::WAY_BITS-1:0]  victim_q;
  logic [ssr_pkg::ADDR_BITS-1:0] best_q;
  logic [ssr_pkg::CNT_BITS-1:0]  minr_q;

  ssr_pkg::way_entry_t           cur;
  logic [ssr_pkg::CNT_BITS-1:0]  cur_r;
  logic [ssr_pkg::ADDR_BITS-1:0] cur_d;
  logic                          low_reuse;

  always_comb begin
    cur = way_rd[0];
    for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
      if (ssr_pkg::WAY_BITS'(w) == cmd.way_idx) cur = way_rd[w];
    end
  end

  assign cur_r     = reuse_f(rt_rd, cur.sig);
  assign cur_d     = (cur.addr >= meta_rd.prev) ? cur.addr - meta_rd.prev
                                                : meta_rd.prev - cur.addr;
  assign low_reuse = (cur_r < reuse_thr);
  assign stat.scan_stop = cmd.scan && !st_q && low_reuse && cur.rrip == ssr_pkg::RR_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      vfound <= 1'b0;
    end else if (cmd.strm) begin
      vfound <= 1'b0;
    end else if (cmd.scan) begin
      if (st_q) begin
        if (low_reuse && (!vfound || cur_d > best_q)) vfound <= 1'b1;
      end else begin
        vfound <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.strm) st_q <= strm_f(hist_rd, meta_rd.scnt, stride, stride_thr);
    if (cmd.scan) begin
      if (st_q) begin
        if (low_reuse && (!vfound || cur_d > best_q)) begin
          victim_q <= cmd.way_idx;
          best_q   <= cur_d;
        end
      end else if (stat.scan_stop || !vfound || cur_r < minr_q) begin
        victim_q <= cmd.way_idx;
        minr_q   <= cur_r;
      end
    end
  end

  // RRIP aging fallback: up to two aging rounds, way 0 if none is at max before or after the first round
  ssr_pkg::way_row_t            way_aged;
  logic [ssr_pkg::WAY_BITS-1:0] age_victim;

  always_comb begin
    logic got;
    got        = 1'b0;
    age_victim = '0;
    way_aged   = way_rd;
    for (int p = 0; p < 2; p++) begin
      for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
        if (!got && way_aged[w].rrip == ssr_pkg::RR_MAX) begin
          got        = 1'b1;
          age_victim = ssr_pkg::WAY_BITS'(w);
        end
      end
      if (!got) begin
        for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
          if (way_aged[w].rrip < ssr_pkg::RR_MAX) way_aged[w].rrip = way_aged[w].rrip + 1'b1;
        end
      end
    end
  end

  // ---------------- write ports ----------------
  always_comb begin
    ssr_pkg::way_row_t way_clr;
    for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
      way_clr[w].rrip = ssr_pkg::RR_MAX;
      way_clr[w].sig  = '0;
      way_clr[w].addr = '0;
    end
    way_we  = cmd.clear || (cmd.fin && !vfound) || (cmd.upd2 && way_ok);
    way_wr  = cmd.clear ? way_clr : (cmd.fin ? way_aged : way_upd);
    rt_we   = cmd.clear || cmd.upd2;
    rt_wr   = cmd.clear ? '0 : rt_n;
    meta_we = cmd.clear || cmd.upd2;
    meta_wr = '0;
    if (!cmd.clear) begin
      meta_wr.scnt = scnt_n;
      meta_wr.prev = addr_q;
      meta_wr.ins  = ins_n;
    end
    hist_we = cmd.upd2;
  end

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin || cmd.upd2;
    end
    if (cmd.fin) begin
      victim_way     <= vfound ? victim_q : age_victim;
      streaming_seen <= st_q;
    end else if (cmd.upd2) begin
      victim_way     <= '0;
      streaming_seen <= st2;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !(way_we || rt_we || meta_we || hist_we))
    else $error("memory written during way scan");
  a_fin_nonstream_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && !st_q) |-> vfound)
    else $error("non-streaming scan ended without victim");
`endif

endmodule

`default_nettype wire

>>> rtl/core/signature_stride_rrip_replacement_unit.sv
// ----------------------------------------------------------------------------
// signature_stride_rrip_replacement_unit
// Top level: configuration registers, sequencer and datapath.
// ----------------------------------------------------------------------------
// Update: fetch, train and write (LOAD, UPD1, UPD2), then done strobes from a register.
// Query: fetch, stream check, scan of N = 1..16 ways one per cycle, finish; then done strobes.
// One transaction at a time; the next start is taken in the done cycle.
// Reset: a clearing pass over all 2048 set rows, busy high meanwhile.
// Results are shown one cycle on done; the receiver cannot stall.
`default_nettype none

module signature_stride_rrip_replacement_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [10:0] set_index,
  input  wire logic [3:0]  way_index,
  input  wire logic [47:0] address,
  input  wire logic [15:0] pc_low,
  input  wire logic        was_hit,
  output logic             done,
  output logic [3:0]       victim_way,
  output logic             streaming_seen,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [ssr_pkg::THR_BITS-1:0] reuse_thr;
  logic [ssr_pkg::THR_BITS-1:0] stride_thr;
  ssr_pkg::dp_cmd_t             cmd;
  ssr_pkg::dp_stat_t            stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_thr  <= ssr_pkg::REUSE_THR_RESET;
      stride_thr <= ssr_pkg::STRIDE_THR_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == ssr_pkg::REG_REUSE_THR) reuse_thr <= pwdata[ssr_pkg::THR_BITS-1:0];
      else stride_thr <= pwdata[ssr_pkg::THR_BITS-1:0];
    end
  end

  assign prdata = (paddr[2] == ssr_pkg::REG_STRIDE_THR) ? {28'd0, stride_thr}
                                                        : {28'd0, reuse_thr};

  ssr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  ssr_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .set_in(set_index[ssr_pkg::SET_BITS-1:0]), .way_in(way_index),
    .addr_in(address), .pc_in(pc_low), .hit_in(was_hit),
    .reuse_thr(reuse_thr), .stride_thr(stride_thr),
    .stat(stat), .done(done), .victim_way(victim_way),
    .streaming_seen(streaming_seen)
  );

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_reset_busy: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy after reset");
`endif

endmodule

`default_nettype wire
